>>> sv/ket_pkg.sv
// shared types, event codes and the key translation table for the key event translator
`default_nettype none
package ket_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned ParamW = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned CodeW  = 11;

  typedef enum logic [KindW-1:0] {
    KIND_DOWN  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_UP    = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  // one registered input beat
  typedef struct packed {
    kind_e              kind;
    logic [ParamW-1:0]  param;
  } item_t;

  // result handed from the core to the output register
  typedef struct packed {
    logic                     valid;
    logic signed [CodeW-1:0]  code;
  } result_t;

  localparam logic [ParamW-1:0] KeyBackspace = 8'd8;
  localparam logic [CharW-1:0]  ChrBackspace = 7'd8;
  localparam logic [CharW-1:0]  ChrCr        = 7'd13;
  localparam logic signed [CodeW-1:0] CodeDel     = 11'sd127;
  localparam logic signed [CodeW-1:0] CodeLf      = 11'sd10;
  localparam logic signed [CodeW-1:0] CodeDefBase = 11'sd410;

  // map a held virtual key code to its special key code
  function automatic logic signed [CodeW-1:0] map_key(input logic [ParamW-1:0] k);
    logic signed [CodeW-1:0] v;
    begin
      case (k)
        8'd1:    v = 11'sd401;
        8'd2:    v = 11'sd402;
        8'd3:    v = 11'sd404;
        8'd4:    v = 11'sd403;
        8'd8:    v = CodeDel;
        8'd13:   v = CodeLf;
        8'd33:   v = 11'sd315;
        8'd34:   v = 11'sd316;
        8'd35:   v = 11'sd318;
        8'd36:   v = 11'sd317;
        8'd37:   v = 11'sd276;
        8'd38:   v = 11'sd274;
        8'd39:   v = 11'sd277;
        8'd40:   v = 11'sd275;
        8'd45:   v = 11'sd312;
        8'd46:   v = 11'sd313;
        8'd120:  v = 11'sd310;
        default: v = CodeDefBase + signed'({3'b000, k});
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/ket_in_stage.sv
// input register stage: captures one event beat per cycle while it is not stalled
`default_nettype none
module ket_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire ket_pkg::item_t in_item_i,
  input  wire logic           advance_i,
  output logic                stall_o,
  output logic                valid_o,
  output ket_pkg::item_t      item_o
);
  import ket_pkg::*;

  logic  valid_q;
  item_t item_q;

  // the held beat leaves whenever the downstream side moves
  assign stall_o = valid_q && !advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !stall_o) begin
      item_q <= in_item_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/ket_core.sv
// translation logic and the held key and character registers
`default_nettype none
module ket_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire ket_pkg::item_t item_i,
  output ket_pkg::result_t    res_o
);
  import ket_pkg::*;

  logic [ParamW-1:0] held_key_q, held_key_d;
  logic [CharW-1:0]  held_char_q, held_char_d;
  logic [ParamW-1:0] companion;
  logic              key_hit;
  logic signed [CodeW-1:0] xlat;

  // companion key for the backspace pairing
  assign companion = (item_i.kind == KIND_DOWN) ? item_i.param : held_key_q;
  assign key_hit   = (held_key_q == item_i.param) && (held_key_q != '0);

  // translate the held pair
  always_comb begin
    if (held_char_q != '0) begin
      if (held_char_q == ChrBackspace && companion == KeyBackspace) begin
        xlat = CodeDel;
      end else if (held_char_q == ChrCr) begin
        xlat = CodeLf;
      end else begin
        xlat = signed'({4'b0000, held_char_q});
      end
    end else begin
      xlat = map_key(held_key_q);
    end
  end

  // per event kind: result and next holds
  always_comb begin
    res_o.valid = 1'b0;
    res_o.code  = xlat;
    held_key_d  = '0;
    held_char_d = '0;
    case (item_i.kind)
      KIND_DOWN: begin
        if (held_char_q != '0 || key_hit) begin
          res_o.valid = 1'b1;
        end else begin
          held_key_d = item_i.param;
        end
      end
      KIND_CHAR: begin
        if (!item_i.param[ParamW-1]) begin
          held_key_d  = held_key_q;
          held_char_d = item_i.param[CharW-1:0];
        end else begin
          res_o.valid = 1'b1;
          res_o.code  = signed'({{(CodeW-ParamW){1'b1}}, item_i.param});
        end
      end
      KIND_UP: begin
        res_o.valid = 1'b1;
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

  // hold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_key_q  <= '0;
      held_char_q <= '0;
    end else if (step_i) begin
      held_key_q  <= held_key_d;
      held_char_q <= held_char_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/key_event_translator.sv
// key event translator: keyboard events in, translated key codes out
// pipeline: two register stages; an accepted event beat is held in the input
// register and its result is then captured in the result register
// throughput: one event per cycle; the input and result registers both
// advance whenever the result register is empty or its beat is taken
// reset: asynchronous, clears both holds and all valid flags
`default_nettype none
module key_event_translator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               event_valid_i,
  output logic                                    event_stall_o,
  input  wire logic [ket_pkg::KindW-1:0]          event_kind_i,
  input  wire logic [ket_pkg::ParamW-1:0]         event_param_i,
  output logic                                    key_valid_o,
  input  wire logic                               key_stall_i,
  output logic signed [ket_pkg::CodeW-1:0]        key_code_o
);
  import ket_pkg::*;

  logic    advance;
  logic    st_valid;
  item_t   in_item, st_item;
  result_t res;
  logic    out_valid_q;
  logic signed [CodeW-1:0] key_code_q;

  assign in_item.kind  = kind_e'(event_kind_i);
  assign in_item.param = event_param_i;

  // pipeline moves when the result register can take a beat
  assign advance = !out_valid_q || !key_stall_i;

  ket_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (event_valid_i),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .stall_o    (event_stall_o),
    .valid_o    (st_valid),
    .item_o     (st_item)
  );

  ket_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (st_valid && advance),
    .item_i (st_item),
    .res_o  (res)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= st_valid && res.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance && st_valid && res.valid) begin
      key_code_q <= res.code;
    end
  end

  assign key_valid_o = out_valid_q;
  assign key_code_o  = key_code_q;

endmodule
`default_nettype wire
